>>> rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic [7:0] NulChar   = 8'h00;
  localparam logic [7:0] PadChar   = 8'h3d;
  localparam logic [7:0] PlusChar  = 8'h2b;
  localparam logic [7:0] SlashChar = 8'h2f;
  localparam logic [5:0] PlusVal   = 6'h3e;
  localparam logic [5:0] SlashVal  = 6'h3f;

  // Most results per character: a full group gives three bytes.
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_status;
    logic       status;
    logic       last;
  } res_t;

  // Return {hit, value} for one character of the standard alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == PlusChar) begin
      r = {1'b1, PlusVal};
    end else if (c == SlashChar) begin
      r = {1'b1, SlashVal};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/b64d_char_if.sv
`timescale 1ns / 1ps

interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

>>> rtl/core/b64d_result_if.sv
`timescale 1ns / 1ps

interface b64d_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_status;
  logic       status;
  logic       last;

  modport source (output valid, output data_byte, output is_status, output status,
                  output last, input ready);
  modport sink (input valid, input data_byte, input is_status, input status,
                input last, output ready);
endinterface

>>> rtl/core/b64d_fifo.sv
`timescale 1ns / 1ps

module b64d_fifo import b64d_pkg::*; #(
  parameter int unsigned Depth = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  res_t                       push_ent_i [MaxResults],
  input  logic                       pop_i,
  output res_t                       head_o,
  output logic [$clog2(Depth+1)-1:0] fill_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned FW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FW-1:0]   fill_q, fill_d;

  // Pointers wrap naturally: Depth is a power of two.
  always_comb begin
    wr_ptr_d = wr_ptr_q + AW'(push_n_i);
    rd_ptr_d = rd_ptr_q + AW'(pop_i);
    fill_d   = fill_q + FW'(push_n_i) - FW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (2'(k) < push_n_i) begin
        mem_q[wr_ptr_q + AW'(k)] <= push_ent_i[k];
      end
    end
  end

  assign head_o = mem_q[rd_ptr_q];
  assign fill_o = fill_q;

endmodule

>>> rtl/core/base64_decoder_unit.sv
`timescale 1ns / 1ps

// Channel   Role    Beat payload                          Accepted when
// char_i    sink    char_code[7:0]                        valid && ready
// res_o     source  data_byte, is_status, status, last    valid && ready
//
// Pipeline: a character is taken into an input register, decoded in the next cycle
// and its 0 to 3 results are pushed into a result queue. One character per cycle
// is sustained while the queue keeps room: ready is high when queue fill plus the
// results of the character in flight leave room for three more, and the queue
// drains one beat per cycle while the result side is ready.
// Reset: asynchronous, active low; clears the group state, the flags and the queue.
// Stalls: a stalled result side holds the queue head; input stalls only when the
// queue is near full (FifoDepth, a power of two of at least 4).

module base64_decoder_unit import b64d_pkg::*; #(
  parameter int unsigned FifoDepth = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  b64d_char_if.sink        char_i,
  b64d_result_if.source    res_o
);

  localparam int unsigned FW = $clog2(FifoDepth + 1);

  // Input register
  logic       in_vq_q;
  logic [7:0] char_q;

  // Decoder state
  logic [1:0]  gp_q, gp_d;
  logic [17:0] held_q, held_d;
  logic        twp_q, twp_d;
  logic        stop_q, stop_d;
  logic        mal_q, mal_d;

  // Decode of the registered character
  logic [6:0] sx;
  logic       pad, pad3, pad4, vok;
  logic [5:0] v, s0, s1, s2;
  logic [7:0] b0, b1, b2;
  logic [1:0] n_res;
  res_t       ent [MaxResults];

  // Queue
  res_t          head;
  logic [FW-1:0] fill;
  logic          pop;
  logic [FW:0]   room_need;

  // Reserve room for whatever the character in flight will push.
  assign room_need    = {1'b0, fill} + (FW+1)'(n_res);
  assign char_i.ready = room_need <= (FW+1)'(FifoDepth - MaxResults);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq_q <= 1'b0;
    end else begin
      in_vq_q <= char_i.valid && char_i.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.char_code;
    end
  end

  assign sx   = sextet_of(char_q);
  assign pad  = char_q == PadChar;
  assign pad3 = pad && (gp_q == 2'd2);
  assign pad4 = pad && (gp_q == 2'd3);
  // A pad at the third or fourth place stands for a zero sextet.
  assign vok  = sx[6] || pad3 || pad4;
  assign v    = (pad3 || pad4) ? 6'd0 : sx[5:0];

  assign s0 = held_q[17:12];
  assign s1 = held_q[11:6];
  assign s2 = held_q[5:0];
  assign b0 = {s0, s1[5:4]};
  assign b1 = {s1[3:0], s2[5:2]};
  assign b2 = {s2[1:0], v};

  always_comb begin
    gp_d   = gp_q;
    held_d = held_q;
    twp_d  = twp_q;
    stop_d = stop_q;
    mal_d  = mal_q;
    n_res  = 2'd0;
    for (int k = 0; k < MaxResults; k++) begin
      ent[k] = '0;
    end
    if (in_vq_q) begin
      if (char_q == NulChar) begin
        // End of string: report and rearm for the next string.
        n_res            = 2'd1;
        ent[0].is_status = 1'b1;
        ent[0].status    = mal_q || (gp_q != 2'd0);
        ent[0].last      = 1'b1;
        gp_d             = 2'd0;
        held_d           = '0;
        twp_d            = 1'b0;
        stop_d           = 1'b0;
        mal_d            = 1'b0;
      end else if (!(mal_q || stop_q)) begin
        if (!vok) begin
          // Bad character or early pad: drop the rest up to the NUL.
          mal_d = 1'b1;
        end else if (gp_q != 2'd3) begin
          held_d = {held_q[11:0], v};
          gp_d   = gp_q + 2'd1;
          if (pad3) begin
            twp_d = 1'b1;
          end
        end else begin
          // Fourth character closes the group.
          gp_d             = 2'd0;
          held_d           = '0;
          ent[0].data_byte = b0;
          ent[1].data_byte = b1;
          ent[2].data_byte = b2;
          if (twp_q) begin
            twp_d          = 1'b0;
            stop_d         = 1'b1;
            n_res          = 2'd1;
            ent[0].last    = 1'b1;
          end else if (pad4) begin
            stop_d         = 1'b1;
            n_res          = 2'd2;
            ent[1].last    = 1'b1;
          end else begin
            n_res          = 2'd3;
            ent[2].last    = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q   <= 2'd0;
      held_q <= '0;
      twp_q  <= 1'b0;
      stop_q <= 1'b0;
      mal_q  <= 1'b0;
    end else begin
      gp_q   <= gp_d;
      held_q <= held_d;
      twp_q  <= twp_d;
      stop_q <= stop_d;
      mal_q  <= mal_d;
    end
  end

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (n_res),
    .push_ent_i (ent),
    .pop_i      (pop),
    .head_o     (head),
    .fill_o     (fill)
  );

  // Advance the queue head on each taken result beat.
  assign res_o.valid     = fill != '0;
  assign pop             = res_o.valid && res_o.ready;
  assign res_o.data_byte = head.data_byte;
  assign res_o.is_status = head.is_status;
  assign res_o.status    = head.status;
  assign res_o.last      = head.last;

  // The room reserve must keep every push inside the queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vq_q |-> ({1'b0, fill} + (FW+1)'(n_res)) <= (FW+1)'(FifoDepth))
    else $error("result queue overflow");

  // A NUL always yields exactly one status beat.
  a_nul_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vq_q && char_q == NulChar) |-> (n_res == 2'd1 && ent[0].is_status))
    else $error("NUL without status result");

  // A status beat always closes its character's results.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.is_status) |-> res_o.last)
    else $error("status beat without last");

  // Once malformed, nothing but the NUL produces results.
  a_mal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vq_q && mal_q && char_q != NulChar) |-> n_res == 2'd0)
    else $error("result after malformed input");

endmodule

>>> tb/sv/b64d_checker.sv
`timescale 1ns / 1ps

module b64d_checker import b64d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_char_if        char_mon,
  b64d_result_if      res_mon,
  output int unsigned mismatches_o,
  output int unsigned owed_o
);

  // Decoder state mirrored from the character stream.
  logic [1:0]  grp_pos;
  logic [17:0] sextets;
  logic        pad_third;
  logic        data_done;
  logic        broken;

  res_t        owed_q[$];
  int unsigned mismatches;

  function automatic logic [6:0] alphabet_value(input logic [7:0] c);
    if (c inside {[8'h41:8'h5a]}) return {1'b1, 6'(c - 8'h41)};
    if (c inside {[8'h61:8'h7a]}) return {1'b1, 6'(c - 8'h47)};
    if (c inside {[8'h30:8'h39]}) return {1'b1, 6'(c + 8'h04)};
    if (c == PlusChar) return {1'b1, PlusVal};
    if (c == SlashChar) return {1'b1, SlashVal};
    return 7'h00;
  endfunction

  task automatic owe(input logic [7:0] d, input logic is_st, input logic st,
                     input logic lst);
    res_t r;
    r.data_byte = d;
    r.is_status = is_st;
    r.status    = st;
    r.last      = lst;
    owed_q.push_back(r);
  endtask

  task automatic clear_string();
    grp_pos   = 2'd0;
    sextets   = '0;
    pad_third = 1'b0;
    data_done = 1'b0;
    broken    = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] c);
    logic [6:0]  hit;
    logic        fourth_pad;
    logic [23:0] word;
    if (c == NulChar) begin
      owe(8'h00, 1'b1, broken || (grp_pos != 2'd0), 1'b1);
      clear_string();
      return;
    end
    if (broken || data_done) return;
    hit = alphabet_value(c);
    fourth_pad = 1'b0;
    if (c == PadChar && grp_pos == 2'd2) begin
      pad_third = 1'b1;
      hit = 7'h40;
    end else if (c == PadChar && grp_pos == 2'd3) begin
      fourth_pad = 1'b1;
      hit = 7'h40;
    end
    if (!hit[6]) begin
      broken = 1'b1;
      return;
    end
    if (grp_pos != 2'd3) begin
      sextets = {sextets[11:0], hit[5:0]};
      grp_pos = grp_pos + 2'd1;
      return;
    end
    word    = {sextets, hit[5:0]};
    grp_pos = 2'd0;
    sextets = '0;
    if (pad_third) begin
      pad_third = 1'b0;
      data_done = 1'b1;
      owe(word[23:16], 1'b0, 1'b0, 1'b1);
    end else if (fourth_pad) begin
      data_done = 1'b1;
      owe(word[23:16], 1'b0, 1'b0, 1'b0);
      owe(word[15:8], 1'b0, 1'b0, 1'b1);
    end else begin
      owe(word[23:16], 1'b0, 1'b0, 1'b0);
      owe(word[15:8], 1'b0, 1'b0, 1'b0);
      owe(word[7:0], 1'b0, 1'b0, 1'b1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      clear_string();
      owed_q.delete();
      mismatches = 0;
    end else begin
      // A character is decoded here before its first result beat can arrive.
      if (char_mon.valid && char_mon.ready) begin
        decode_char(char_mon.char_code);
      end
      if (res_mon.valid && res_mon.ready) begin
        got.data_byte = res_mon.data_byte;
        got.is_status = res_mon.is_status;
        got.status    = res_mon.status;
        got.last      = res_mon.last;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (got.data_byte !== want.data_byte || got.is_status !== want.is_status ||
              got.status !== want.status || got.last !== want.last) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            mismatches++;
          end
        end
      end
    end
    mismatches_o = mismatches;
    owed_o       = owed_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import b64d_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;
  // Random characters to send after the directed strings.
  localparam int unsigned RandomChars = 230;

  logic clk_i;
  logic rst_ni;

  b64d_char_if   char_bus();
  b64d_result_if res_bus();

  int unsigned mismatches;
  int unsigned owed;

  // Idle and stall percentages for the current phase.
  int unsigned idle_pct;
  int unsigned stall_pct;

  // Characters of the string being sent, NUL included.
  logic [7:0] text_q[$];

  base64_decoder_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .res_o  (res_bus)
  );

  b64d_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_mon     (char_bus),
    .res_mon      (res_bus),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: hold ready low for a random share of cycles, changed on the
  // falling edge so the block sees a stable value at the rising edge.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((char_bus.valid && char_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: errors");
    $finish;
  end

  // Map a 6-bit value to its character in the standard alphabet.
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == PlusVal) return PlusChar;
    return SlashChar;
  endfunction

  function automatic logic [7:0] any_alpha();
    return alpha_char(6'($urandom_range(63)));
  endfunction

  // Called at a falling edge; return at the falling edge after the beat.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      char_bus.valid     <= 1'b0;
      char_bus.char_code <= 8'($urandom_range(255));
      @(negedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    do @(posedge clk_i); while (!(char_bus.valid && char_bus.ready));
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) begin
      send_char(text_q[i]);
    end
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(8'(s[i]));
    end
  endtask

  // Build one random string. Most are well formed: full groups of random
  // alphabet characters and an optional padded tail, sometimes followed by
  // junk that must be ignored. The rest get a stray byte, a misplaced pad,
  // extra characters at the end, or are plain noise.
  task automatic build_random_text();
    int unsigned kind;
    int unsigned groups;
    int unsigned ending;
    int unsigned pos;
    kind   = $urandom_range(99);
    groups = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(3);
    if (kind < 8) begin
      repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255, 1)));
    end else begin
      repeat (4 * groups) text_q.push_back(any_alpha());
      ending = $urandom_range(3);
      case (ending)
        1: begin
          text_q.push_back(any_alpha());
          text_q.push_back(any_alpha());
          text_q.push_back(PadChar);
          text_q.push_back(PadChar);
        end
        2: begin
          repeat (3) text_q.push_back(any_alpha());
          text_q.push_back(PadChar);
        end
        3: begin
          text_q.push_back(any_alpha());
          text_q.push_back(any_alpha());
          text_q.push_back(PadChar);
          text_q.push_back(any_alpha());
        end
        default: ;
      endcase
      if (ending != 0 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) text_q.push_back(8'($urandom_range(255, 1)));
      end
      if (kind < 30) begin
        pos = $urandom_range(text_q.size());
        case ($urandom_range(2))
          0: text_q.insert(pos, 8'($urandom_range(255, 1)));
          1: text_q.insert(pos, PadChar);
          default: begin
            // Append one to three letters so the string may end inside a group.
            repeat ($urandom_range(3, 1)) text_q.push_back(any_alpha());
          end
        endcase
      end
    end
    text_q.push_back(NulChar);
  endtask

  initial begin
    int unsigned sent;
    rst_ni             = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = 8'h00;
    idle_pct           = 0;
    stall_pct          = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed strings: empty string; plus, slash, digit and lowercase in a
    // full group; pad at the third place with a letter after it, nonzero
    // unused bits and ignored text after the pad; pad at the fourth place;
    // early pad; a byte outside the alphabet; a string cut inside a group.
    text_q.push_back(NulChar);
    add_str("+/9z");
    text_q.push_back(NulChar);
    add_str("TR=AZ");
    text_q.push_back(NulChar);
    add_str("TWE=");
    text_q.push_back(NulChar);
    add_str("A=");
    text_q.push_back(NulChar);
    text_q.push_back(8'hff);
    text_q.push_back(NulChar);
    add_str("AB");
    text_q.push_back(NulChar);
    send_text();

    // Random strings through the idling phases: none, sender idle,
    // receiver stalling, both.
    sent = 0;
    while (sent < RandomChars) begin
      case (sent * 4 / RandomChars)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 60;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 60;
        end
        default: begin
          idle_pct  = 18;
          stall_pct = 18;
        end
      endcase
      build_random_text();
      sent += text_q.size();
      send_text();
    end
    char_bus.valid <= 1'b0;

    // Drain: let the result side run free until nothing is owed, then give
    // stray beats a few cycles to show up.
    stall_pct = 0;
    wait (owed == 0);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && owed == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
